>>> rtl/core/cpu6502_subset_execute_macros.svh
// assertion macros for the subset 6502 execute block
`ifndef CPU6502_SUBSET_EXECUTE_MACROS_SVH
`define CPU6502_SUBSET_EXECUTE_MACROS_SVH
`ifndef SYNTHESIS
`define CSE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cse assertion failed");
`define CSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cse assertion failed");
`else
`define CSE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CSE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/cse_pkg.sv
// types and constants shared by the subset 6502 execute block
`default_nettype none
package cse_pkg;

   // opcodes of the supported subset
   localparam logic [7:0] OPC_LDA = 8'hA9;
   localparam logic [7:0] OPC_LDX = 8'hA2;
   localparam logic [7:0] OPC_LDY = 8'hA0;
   localparam logic [7:0] OPC_STA = 8'h85;
   localparam logic [7:0] OPC_STX = 8'h86;
   localparam logic [7:0] OPC_STY = 8'h84;
   localparam logic [7:0] OPC_TAX = 8'hAA;
   localparam logic [7:0] OPC_TAY = 8'hA8;
   localparam logic [7:0] OPC_TXA = 8'h8A;
   localparam logic [7:0] OPC_TYA = 8'h98;
   localparam logic [7:0] OPC_TSX = 8'hBA;
   localparam logic [7:0] OPC_TXS = 8'h9A;
   localparam logic [7:0] OPC_PHA = 8'h48;
   localparam logic [7:0] OPC_PHP = 8'h08;
   localparam logic [7:0] OPC_PLA = 8'h68;
   localparam logic [7:0] OPC_PLP = 8'h28;
   localparam logic [7:0] OPC_AND = 8'h29;
   localparam logic [7:0] OPC_EOR = 8'h49;
   localparam logic [7:0] OPC_ORA = 8'h09;
   localparam logic [7:0] OPC_BIT = 8'h24;
   localparam logic [7:0] OPC_ADC = 8'h69;
   localparam logic [7:0] OPC_SBC = 8'hE9;
   localparam logic [7:0] OPC_CMP = 8'hC9;
   localparam logic [7:0] OPC_CPX = 8'hE0;
   localparam logic [7:0] OPC_CPY = 8'hC0;
   localparam logic [7:0] OPC_INC = 8'hE6;
   localparam logic [7:0] OPC_DEC = 8'hC6;
   localparam logic [7:0] OPC_INX = 8'hE8;
   localparam logic [7:0] OPC_INY = 8'hC8;
   localparam logic [7:0] OPC_DEX = 8'hCA;
   localparam logic [7:0] OPC_DEY = 8'h88;
   localparam logic [7:0] OPC_ASL = 8'h0A;
   localparam logic [7:0] OPC_LSR = 8'h4A;
   localparam logic [7:0] OPC_ROL = 8'h2A;
   localparam logic [7:0] OPC_ROR = 8'h6A;
   localparam logic [7:0] OPC_JMP = 8'h4C;
   localparam logic [7:0] OPC_JSR = 8'h20;
   localparam logic [7:0] OPC_RTS = 8'h60;

   // status bit positions and masks
   localparam int unsigned FLG_C = 0;
   localparam int unsigned FLG_Z = 1;
   localparam int unsigned FLG_V = 6;
   localparam int unsigned FLG_N = 7;
   localparam logic [7:0] FLG_MASK_BU = 8'h30;
   localparam logic [7:0] FLG_MASK_ONE = 8'h20;
   localparam logic [7:0] BYTE_ONES = 8'hFF;

   // stack page and clearing sweep
   localparam logic STACK_PAGE = 1'b1;
   localparam logic ZERO_PAGE = 1'b0;
   localparam int unsigned USED_BYTES = 512;
   localparam int unsigned USED_AW = 9;

   typedef enum logic [5:0] {
      OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY,
      OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS,
      OP_PHA, OP_PHP, OP_PLA, OP_PLP,
      OP_AND, OP_EOR, OP_ORA, OP_BIT, OP_ADC, OP_SBC,
      OP_CMP, OP_CPX, OP_CPY, OP_INC, OP_DEC,
      OP_INX, OP_INY, OP_DEX, OP_DEY,
      OP_ASL, OP_LSR, OP_ROL, OP_ROR,
      OP_JMP, OP_JSR, OP_RTS, OP_BAD
   } op_type;

   typedef enum logic [2:0] {
      BK_CLEAR, BK_READ, BK_READ2, BK_EXEC, BK_WRITE2
   } back_state_type;

   // classified instruction between front and back
   typedef struct packed {
      op_type      op;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [1:0]  len;
   } dec_type;

   // reported registers
   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [15:0] pc;
      logic [7:0]  flags;
      logic        unknown;
   } res_type;

endpackage
`default_nettype wire

>>> rtl/core/cpu6502_subset_execute.sv
// Subset 6502 executor: each item is one instruction (opcode and two operand
// bytes); each result reports A, X, Y, SP, PC and the status byte after it.
// Most instructions pass through BK_READ for the ram read and BK_EXEC to
// execute and write back; RTS adds BK_READ2 and JSR adds BK_WRITE2, as the
// single ram port carries their second stack byte in a state of its own. A
// two-entry queue on each side lets transfers continue while the other side
// stalls. After reset a clearing pass zeroes pages zero and one, during which
// full stays high.
`default_nettype none
`include "cpu6502_subset_execute_macros.svh"
module cpu6502_subset_execute import cse_pkg::*; #(
   parameter int unsigned RAM_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_operation,
   input  wire logic [7:0]  req_operand_low,
   input  wire logic [7:0]  req_operand_high,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_acc_out,
   output logic [7:0]       rsp_x_out,
   output logic [7:0]       rsp_y_out,
   output logic [7:0]       rsp_sp_out,
   output logic [15:0]      rsp_pc_out,
   output logic [7:0]       rsp_flags_out,
   output logic             rsp_unknown_opcode
);

   dec_type que_item;
   logic    que_empty, que_pop, que_full;
   logic    out_full, res_push, clearing;
   res_type res, res_head;

   // input blocked during the ram clearing pass
   assign full = que_full || clearing;

   cse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push && !clearing),
      .operation    (req_operation),
      .operand_low  (req_operand_low),
      .operand_high (req_operand_high),
      .full         (que_full),
      .que_pop      (que_pop),
      .que_item     (que_item),
      .que_empty    (que_empty)
   );

   cse_back #(.RAM_BYTES(RAM_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .que_empty (que_empty),
      .que_item  (que_item),
      .que_pop   (que_pop),
      .out_full  (out_full),
      .res_push  (res_push),
      .res       (res),
      .clearing  (clearing)
   );

   // result queue
   cse_fifo #(.WIDTH($bits(res_type))) u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (res_head),
      .empty     (empty)
   );

   assign rsp_acc_out        = res_head.acc;
   assign rsp_x_out          = res_head.x;
   assign rsp_y_out          = res_head.y;
   assign rsp_sp_out         = res_head.sp;
   assign rsp_pc_out         = res_head.pc;
   assign rsp_flags_out      = res_head.flags;
   assign rsp_unknown_opcode = res_head.unknown;

   // checks
   `CSE_ASSERT_NOW(a_one_result_per_item, clock, reset, res_push, que_pop && !que_empty)
   `CSE_ASSERT_NOW(a_no_result_in_clear, clock, reset, clearing, !res_push && full)
   `CSE_ASSERT_NEXT(a_result_queued, clock, reset, res_push && empty, !empty)

endmodule
`default_nettype wire

>>> rtl/core/cse_ram.sv
// generic single write port ram with registered read
`default_nettype none
module cse_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/core/cse_fifo.sv
// two-entry queue used between the stages
`default_nettype none
module cse_fifo #(
   parameter int unsigned WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   // pointer and fill count update
   always_comb begin
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = wr_ff ^ do_push;
      rd_in   = rd_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   assign full     = cnt_ff[1];
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/cse_front.sv
// front end: classifies opcodes and queues them for execution
`default_nettype none
module cse_front import cse_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [7:0] operation,
   input  wire logic [7:0] operand_low,
   input  wire logic [7:0] operand_high,
   output logic            full,
   input  wire logic       que_pop,
   output dec_type         que_item,
   output logic            que_empty
);

   dec_type dec;
   logic    que_full;

   // opcode decoder
   always_comb begin
      dec.lo  = operand_low;
      dec.hi  = operand_high;
      dec.len = 2'd1;
      unique case (operation)
         OPC_LDA: begin dec.op = OP_LDA; dec.len = 2'd2; end
         OPC_LDX: begin dec.op = OP_LDX; dec.len = 2'd2; end
         OPC_LDY: begin dec.op = OP_LDY; dec.len = 2'd2; end
         OPC_STA: begin dec.op = OP_STA; dec.len = 2'd2; end
         OPC_STX: begin dec.op = OP_STX; dec.len = 2'd2; end
         OPC_STY: begin dec.op = OP_STY; dec.len = 2'd2; end
         OPC_TAX: dec.op = OP_TAX;
         OPC_TAY: dec.op = OP_TAY;
         OPC_TXA: dec.op = OP_TXA;
         OPC_TYA: dec.op = OP_TYA;
         OPC_TSX: dec.op = OP_TSX;
         OPC_TXS: dec.op = OP_TXS;
         OPC_PHA: dec.op = OP_PHA;
         OPC_PHP: dec.op = OP_PHP;
         OPC_PLA: dec.op = OP_PLA;
         OPC_PLP: dec.op = OP_PLP;
         OPC_AND: begin dec.op = OP_AND; dec.len = 2'd2; end
         OPC_EOR: begin dec.op = OP_EOR; dec.len = 2'd2; end
         OPC_ORA: begin dec.op = OP_ORA; dec.len = 2'd2; end
         OPC_BIT: begin dec.op = OP_BIT; dec.len = 2'd2; end
         OPC_ADC: begin dec.op = OP_ADC; dec.len = 2'd2; end
         OPC_SBC: begin dec.op = OP_SBC; dec.len = 2'd2; end
         OPC_CMP: begin dec.op = OP_CMP; dec.len = 2'd2; end
         OPC_CPX: begin dec.op = OP_CPX; dec.len = 2'd2; end
         OPC_CPY: begin dec.op = OP_CPY; dec.len = 2'd2; end
         OPC_INC: begin dec.op = OP_INC; dec.len = 2'd2; end
         OPC_DEC: begin dec.op = OP_DEC; dec.len = 2'd2; end
         OPC_INX: dec.op = OP_INX;
         OPC_INY: dec.op = OP_INY;
         OPC_DEX: dec.op = OP_DEX;
         OPC_DEY: dec.op = OP_DEY;
         OPC_ASL: dec.op = OP_ASL;
         OPC_LSR: dec.op = OP_LSR;
         OPC_ROL: dec.op = OP_ROL;
         OPC_ROR: dec.op = OP_ROR;
         OPC_JMP: begin dec.op = OP_JMP; dec.len = 2'd0; end
         OPC_JSR: begin dec.op = OP_JSR; dec.len = 2'd0; end
         OPC_RTS: begin dec.op = OP_RTS; dec.len = 2'd0; end
         default: begin dec.op = OP_BAD; dec.len = 2'd0; end
      endcase
   end

   // queue towards the back end
   cse_fifo #(.WIDTH($bits(dec_type))) u_que (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (dec),
      .full      (que_full),
      .pop       (que_pop),
      .pop_data  (que_item),
      .empty     (que_empty)
   );

   assign full = que_full;

endmodule
`default_nettype wire

>>> rtl/core/cse_back.sv
// back end: register file, stack and zero-page ram, instruction execution
`default_nettype none
module cse_back import cse_pkg::*; #(
   parameter int unsigned RAM_BYTES = 512
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic que_empty,
   input  dec_type   que_item,
   output logic      que_pop,
   input  wire logic out_full,
   output logic      res_push,
   output res_type   res,
   output logic      clearing
);

   localparam int unsigned AW = $clog2(RAM_BYTES);

   back_state_type state_ff, state_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  low_ff, low_in;
   logic [USED_AW-1:0] clr_ff, clr_in;

   logic          ram_we;
   logic [USED_AW-1:0] ram_wa, ram_ra;
   logic [7:0]    ram_wd, ram_rd;

   // flags n and z from a value
   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r        = p;
      r[FLG_N] = v[7];
      r[FLG_Z] = (v == 8'd0);
      return r;
   endfunction

   cse_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(ram_wa)),
      .wr_data (ram_wd),
      .rd_addr (AW'(ram_ra)),
      .rd_data (ram_rd)
   );

   // sequencer and execute
   always_comb begin
      logic [7:0]  m;
      logic [8:0]  sum;
      logic [8:0]  diff;
      logic [7:0]  t;
      logic [15:0] ret;
      state_in = state_ff;
      a_in     = a_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      sp_in    = sp_ff;
      p_in     = p_ff;
      pc_in    = pc_ff;
      low_in   = low_ff;
      clr_in   = clr_ff;
      ram_we   = 1'b0;
      ram_wa   = '0;
      ram_wd   = 8'd0;
      ram_ra   = {ZERO_PAGE, que_item.lo};
      que_pop  = 1'b0;
      res_push = 1'b0;
      m        = 8'd0;
      sum      = 9'd0;
      diff     = 9'd0;
      t        = 8'd0;
      ret      = pc_ff + 16'd2;
      unique case (state_ff)
         BK_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == USED_AW'(USED_BYTES - 1)) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (que_item.op == OP_PLA || que_item.op == OP_PLP || que_item.op == OP_RTS) begin
               ram_ra = {STACK_PAGE, sp_ff + 8'd1};
            end
            if (!que_empty) begin
               state_in = (que_item.op == OP_RTS) ? BK_READ2 : BK_EXEC;
            end
         end
         BK_READ2: begin
            low_in   = ram_rd;
            ram_ra   = {STACK_PAGE, sp_ff + 8'd2};
            state_in = BK_EXEC;
         end
         BK_EXEC: begin
            // keep the read address so a stalled pull still sees its byte
            if (que_item.op == OP_PLA || que_item.op == OP_PLP) begin
               ram_ra = {STACK_PAGE, sp_ff + 8'd1};
            end else if (que_item.op == OP_RTS) begin
               ram_ra = {STACK_PAGE, sp_ff + 8'd2};
            end
            if (!out_full) begin
               pc_in = pc_ff + {14'd0, que_item.len};
               case (que_item.op)
                  OP_LDA: begin a_in = que_item.lo; p_in = set_nz(p_ff, a_in); end
                  OP_LDX: begin x_in = que_item.lo; p_in = set_nz(p_ff, x_in); end
                  OP_LDY: begin y_in = que_item.lo; p_in = set_nz(p_ff, y_in); end
                  OP_STA: begin
                     ram_we = 1'b1; ram_wa = {ZERO_PAGE, que_item.lo}; ram_wd = a_ff;
                  end
                  OP_STX: begin
                     ram_we = 1'b1; ram_wa = {ZERO_PAGE, que_item.lo}; ram_wd = x_ff;
                  end
                  OP_STY: begin
                     ram_we = 1'b1; ram_wa = {ZERO_PAGE, que_item.lo}; ram_wd = y_ff;
                  end
                  OP_TAX: begin x_in = a_ff; p_in = set_nz(p_ff, a_ff); end
                  OP_TAY: begin y_in = a_ff; p_in = set_nz(p_ff, a_ff); end
                  OP_TXA: begin a_in = x_ff; p_in = set_nz(p_ff, x_ff); end
                  OP_TYA: begin a_in = y_ff; p_in = set_nz(p_ff, y_ff); end
                  OP_TSX: begin x_in = sp_ff; p_in = set_nz(p_ff, sp_ff); end
                  OP_TXS: sp_in = x_ff;
                  OP_PHA: begin
                     ram_we = 1'b1; ram_wa = {STACK_PAGE, sp_ff}; ram_wd = a_ff;
                     sp_in = sp_ff - 8'd1;
                  end
                  OP_PHP: begin
                     ram_we = 1'b1; ram_wa = {STACK_PAGE, sp_ff};
                     ram_wd = p_ff | FLG_MASK_BU;
                     sp_in = sp_ff - 8'd1;
                  end
                  OP_PLA: begin
                     a_in = ram_rd; p_in = set_nz(p_ff, ram_rd); sp_in = sp_ff + 8'd1;
                  end
                  OP_PLP: begin
                     p_in  = (p_ff & FLG_MASK_BU) | (ram_rd & ~FLG_MASK_BU);
                     sp_in = sp_ff + 8'd1;
                  end
                  OP_AND: begin a_in = a_ff & que_item.lo; p_in = set_nz(p_ff, a_in); end
                  OP_EOR: begin a_in = a_ff ^ que_item.lo; p_in = set_nz(p_ff, a_in); end
                  OP_ORA: begin a_in = a_ff | que_item.lo; p_in = set_nz(p_ff, a_in); end
                  OP_BIT: begin
                     p_in[FLG_N] = ram_rd[7];
                     p_in[FLG_V] = ram_rd[6];
                     p_in[FLG_Z] = ((a_ff & ram_rd) == 8'd0);
                  end
                  OP_ADC, OP_SBC: begin
                     m = (que_item.op == OP_SBC) ? ~que_item.lo : que_item.lo;
                     sum = {1'b0, a_ff} + {1'b0, m} + {8'd0, p_ff[FLG_C]};
                     a_in = sum[7:0];
                     p_in = set_nz(p_ff, sum[7:0]);
                     p_in[FLG_C] = sum[8];
                     p_in[FLG_V] = ~(a_ff[7] ^ m[7]) & (a_ff[7] ^ sum[7]);
                  end
                  OP_CMP, OP_CPX, OP_CPY: begin
                     t = (que_item.op == OP_CMP) ? a_ff :
                         (que_item.op == OP_CPX) ? x_ff : y_ff;
                     diff = {1'b0, t} - {1'b0, que_item.lo};
                     p_in = set_nz(p_ff, diff[7:0]);
                     p_in[FLG_C] = ~diff[8];
                  end
                  OP_INC, OP_DEC: begin
                     t = (que_item.op == OP_INC) ? ram_rd + 8'd1 : ram_rd - 8'd1;
                     ram_we = 1'b1; ram_wa = {ZERO_PAGE, que_item.lo}; ram_wd = t;
                     p_in = set_nz(p_ff, t);
                  end
                  OP_INX: begin x_in = x_ff + 8'd1; p_in = set_nz(p_ff, x_in); end
                  OP_INY: begin y_in = y_ff + 8'd1; p_in = set_nz(p_ff, y_in); end
                  OP_DEX: begin x_in = x_ff - 8'd1; p_in = set_nz(p_ff, x_in); end
                  OP_DEY: begin y_in = y_ff - 8'd1; p_in = set_nz(p_ff, y_in); end
                  OP_ASL, OP_ROL: begin
                     a_in = {a_ff[6:0], (que_item.op == OP_ROL) & p_ff[FLG_C]};
                     p_in = set_nz(p_ff, a_in);
                     p_in[FLG_C] = a_ff[7];
                  end
                  OP_LSR, OP_ROR: begin
                     a_in = {(que_item.op == OP_ROR) & p_ff[FLG_C], a_ff[7:1]};
                     p_in = set_nz(p_ff, a_in);
                     p_in[FLG_C] = a_ff[0];
                  end
                  OP_JMP: pc_in = {que_item.hi, que_item.lo};
                  OP_RTS: begin
                     pc_in = {ram_rd, low_ff} + 16'd1;
                     sp_in = sp_ff + 8'd2;
                  end
                  default: ;
               endcase
               // subroutine call pushes the return address high byte first
               if (que_item.op == OP_JSR) begin
                  ram_we   = 1'b1;
                  ram_wa   = {STACK_PAGE, sp_ff};
                  ram_wd   = ret[15:8];
                  a_in     = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff;
                  p_in     = p_ff; pc_in = pc_ff;
                  state_in = BK_WRITE2;
               end else begin
                  res_push = 1'b1;
                  que_pop  = 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         BK_WRITE2: begin
            ram_we   = 1'b1;
            ram_wa   = {STACK_PAGE, sp_ff - 8'd1};
            ram_wd   = ret[7:0];
            sp_in    = sp_ff - 8'd2;
            pc_in    = {que_item.hi, que_item.lo};
            res_push = 1'b1;
            que_pop  = 1'b1;
            state_in = BK_READ;
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   // result from next register values
   always_comb begin
      res.acc     = a_in;
      res.x       = x_in;
      res.y       = y_in;
      res.sp      = sp_in;
      res.pc      = pc_in;
      res.flags   = p_in | FLG_MASK_ONE;
      res.unknown = (que_item.op == OP_BAD);
   end

   assign clearing = (state_ff == BK_CLEAR);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         a_ff     <= 8'd0;
         x_ff     <= 8'd0;
         y_ff     <= 8'd0;
         sp_ff    <= BYTE_ONES;
         pc_ff    <= 16'd0;
         p_ff     <= 8'd0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         sp_ff    <= sp_in;
         pc_ff    <= pc_in;
         p_ff     <= p_in;
         clr_ff   <= clr_in;
      end
   end

   // pulled low byte of the return address
   always_ff @(posedge clock) begin
      low_ff <= low_in;
   end

endmodule
`default_nettype wire

>>> test/cpu6502_subset_execute_tb.sv
// testbench for the subset 6502 execute block: directed table then random programs
`timescale 1ns / 100ps
`default_nettype none
module cpu6502_subset_execute_tb;
   import cse_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 900;
   localparam int unsigned IDLE_LIMIT = 20000;

   typedef struct {
      logic [7:0] op;
      logic [7:0] lo;
      logic [7:0] hi;
      logic       typed;
      res_type    want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [7:0]  req_operation = '0;
   logic [7:0]  req_operand_low = '0;
   logic [7:0]  req_operand_high = '0;
   logic        full;
   logic        empty;
   logic [7:0]  rsp_acc_out;
   logic [7:0]  rsp_x_out;
   logic [7:0]  rsp_y_out;
   logic [7:0]  rsp_sp_out;
   logic [15:0] rsp_pc_out;
   logic [7:0]  rsp_flags_out;
   logic        rsp_unknown_opcode;

   // architectural state of the predicted processor
   logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
   logic [15:0] cpu_pc;
   logic [7:0]  cpu_ram [0:511];

   res_type     pending_regs [$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          stim_done = 1'b0;
   bit          hold_rx = 1'b0;

   cpu6502_subset_execute u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_operation(req_operation), .req_operand_low(req_operand_low),
      .req_operand_high(req_operand_high), .empty(empty), .pop(pop),
      .rsp_acc_out(rsp_acc_out), .rsp_x_out(rsp_x_out), .rsp_y_out(rsp_y_out),
      .rsp_sp_out(rsp_sp_out), .rsp_pc_out(rsp_pc_out),
      .rsp_flags_out(rsp_flags_out), .rsp_unknown_opcode(rsp_unknown_opcode)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void set_nz(input logic [7:0] v);
      cpu_p[FLG_N] = v[7];
      cpu_p[FLG_Z] = (v == 8'h00);
   endfunction

   function automatic void stack_push(input logic [7:0] v);
      cpu_ram[{STACK_PAGE, cpu_sp}] = v;
      cpu_sp = cpu_sp - 8'd1;
   endfunction

   function automatic logic [7:0] stack_pull();
      cpu_sp = cpu_sp + 8'd1;
      return cpu_ram[{STACK_PAGE, cpu_sp}];
   endfunction

   function automatic void add_carry(input logic [7:0] m);
      logic [8:0] s;
      logic [7:0] r;
      s = {1'b0, cpu_a} + {1'b0, m} + {8'd0, cpu_p[FLG_C]};
      r = s[7:0];
      cpu_p[FLG_C] = s[8];
      cpu_p[FLG_V] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ r[7]);
      cpu_a = r;
      set_nz(r);
   endfunction

   function automatic void compare(input logic [7:0] r, input logic [7:0] m);
      cpu_p[FLG_C] = (r >= m);
      set_nz(r - m);
   endfunction

   // executes one instruction on the predicted state and returns the registers
   function automatic res_type execute_instr(input logic [7:0] op, input logic [7:0] lo,
                                             input logic [7:0] hi);
      res_type     r;
      logic [7:0]  t, h;
      logic [15:0] ret;
      logic [1:0]  len;
      logic        bad;
      len = 2'd1;
      bad = 1'b0;
      case (op)
         OPC_LDA: begin cpu_a = lo; set_nz(lo); len = 2'd2; end
         OPC_LDX: begin cpu_x = lo; set_nz(lo); len = 2'd2; end
         OPC_LDY: begin cpu_y = lo; set_nz(lo); len = 2'd2; end
         OPC_STA: begin cpu_ram[{ZERO_PAGE, lo}] = cpu_a; len = 2'd2; end
         OPC_STX: begin cpu_ram[{ZERO_PAGE, lo}] = cpu_x; len = 2'd2; end
         OPC_STY: begin cpu_ram[{ZERO_PAGE, lo}] = cpu_y; len = 2'd2; end
         OPC_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
         OPC_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
         OPC_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
         OPC_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
         OPC_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
         OPC_TXS: cpu_sp = cpu_x;
         OPC_PHA: stack_push(cpu_a);
         OPC_PHP: stack_push(cpu_p | FLG_MASK_BU);
         OPC_PLA: begin cpu_a = stack_pull(); set_nz(cpu_a); end
         OPC_PLP: begin
            t = stack_pull();
            cpu_p = (cpu_p & FLG_MASK_BU) | (t & ~FLG_MASK_BU);
         end
         OPC_AND: begin cpu_a = cpu_a & lo; set_nz(cpu_a); len = 2'd2; end
         OPC_EOR: begin cpu_a = cpu_a ^ lo; set_nz(cpu_a); len = 2'd2; end
         OPC_ORA: begin cpu_a = cpu_a | lo; set_nz(cpu_a); len = 2'd2; end
         OPC_BIT: begin
            t = cpu_ram[{ZERO_PAGE, lo}];
            cpu_p[FLG_N] = t[7];
            cpu_p[FLG_V] = t[6];
            cpu_p[FLG_Z] = ((cpu_a & t) == 8'h00);
            len = 2'd2;
         end
         OPC_ADC: begin add_carry(lo); len = 2'd2; end
         OPC_SBC: begin add_carry(~lo); len = 2'd2; end
         OPC_CMP: begin compare(cpu_a, lo); len = 2'd2; end
         OPC_CPX: begin compare(cpu_x, lo); len = 2'd2; end
         OPC_CPY: begin compare(cpu_y, lo); len = 2'd2; end
         OPC_INC: begin
            t = cpu_ram[{ZERO_PAGE, lo}] + 8'd1;
            cpu_ram[{ZERO_PAGE, lo}] = t; set_nz(t); len = 2'd2;
         end
         OPC_DEC: begin
            t = cpu_ram[{ZERO_PAGE, lo}] - 8'd1;
            cpu_ram[{ZERO_PAGE, lo}] = t; set_nz(t); len = 2'd2;
         end
         OPC_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
         OPC_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
         OPC_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
         OPC_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
         OPC_ASL: begin
            cpu_p[FLG_C] = cpu_a[7]; cpu_a = {cpu_a[6:0], 1'b0}; set_nz(cpu_a);
         end
         OPC_LSR: begin
            cpu_p[FLG_C] = cpu_a[0]; cpu_a = {1'b0, cpu_a[7:1]}; set_nz(cpu_a);
         end
         OPC_ROL: begin
            t = {cpu_a[6:0], cpu_p[FLG_C]};
            cpu_p[FLG_C] = cpu_a[7]; cpu_a = t; set_nz(t);
         end
         OPC_ROR: begin
            t = {cpu_p[FLG_C], cpu_a[7:1]};
            cpu_p[FLG_C] = cpu_a[0]; cpu_a = t; set_nz(t);
         end
         OPC_JMP: begin cpu_pc = {hi, lo}; len = 2'd0; end
         OPC_JSR: begin
            ret = cpu_pc + 16'd2;
            stack_push(ret[15:8]);
            stack_push(ret[7:0]);
            cpu_pc = {hi, lo};
            len = 2'd0;
         end
         OPC_RTS: begin
            t = stack_pull();
            h = stack_pull();
            cpu_pc = {h, t} + 16'd1;
            len = 2'd0;
         end
         default: begin bad = 1'b1; len = 2'd0; end
      endcase
      cpu_pc = cpu_pc + {14'd0, len};
      r.acc = cpu_a;
      r.x = cpu_x;
      r.y = cpu_y;
      r.sp = cpu_sp;
      r.pc = cpu_pc;
      r.flags = cpu_p | FLG_MASK_ONE;
      r.unknown = bad;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      fail_count++;
   endtask

   // short random gap, now and then a long one
   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // offer one instruction and hold it until the transfer
   task automatic send_instr(input logic [7:0] op, input logic [7:0] lo,
                             input logic [7:0] hi, input logic typed,
                             input res_type want);
      res_type r;
      r = execute_instr(op, lo, hi);
      // typed rows are checked against the value written in the table
      pending_regs.push_back(typed ? want : r);
      push <= 1'b1;
      req_operation <= op;
      req_operand_low <= lo;
      req_operand_high <= hi;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   function automatic logic [7:0] random_opcode();
      logic [7:0] ops [38];
      ops = '{OPC_LDA, OPC_LDX, OPC_LDY, OPC_STA, OPC_STX, OPC_STY, OPC_TAX,
              OPC_TAY, OPC_TXA, OPC_TYA, OPC_TSX, OPC_TXS, OPC_PHA, OPC_PHP,
              OPC_PLA, OPC_PLP, OPC_AND, OPC_EOR, OPC_ORA, OPC_BIT, OPC_ADC,
              OPC_SBC, OPC_CMP, OPC_CPX, OPC_CPY, OPC_INC, OPC_DEC, OPC_INX,
              OPC_INY, OPC_DEX, OPC_DEY, OPC_ASL, OPC_LSR, OPC_ROL, OPC_ROR,
              OPC_JMP, OPC_JSR, OPC_RTS};
      if ($urandom_range(0, 19) == 0) return 8'($urandom);
      return ops[$urandom_range(0, 37)];
   endfunction

   // stimulus: directed table, then random programs
   initial begin
      stim_row_type rows [$];
      res_type      z;
      res_type      unk;
      for (int i = 0; i < 512; i++) cpu_ram[i] = 8'h00;
      cpu_a = '0; cpu_x = '0; cpu_y = '0; cpu_sp = BYTE_ONES; cpu_pc = '0; cpu_p = '0;
      z = '{acc: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFF, pc: 16'h0000,
            flags: 8'h20, unknown: 1'b0};
      unk = z;
      unk.unknown = 1'b1;
      rows = '{
         '{8'hFF, 8'hFF, 8'hFF, 1'b1, unk},
         '{8'h02, 8'h00, 8'h00, 1'b1, unk},
         '{OPC_LDA, 8'h80, 8'h00, 1'b0, z},
         '{OPC_LDA, 8'h00, 8'hFF, 1'b0, z},
         '{OPC_LDA, 8'h7F, 8'h00, 1'b0, z},
         '{OPC_ADC, 8'h01, 8'h00, 1'b0, z},
         '{OPC_SBC, 8'hFF, 8'h00, 1'b0, z},
         '{OPC_ADC, 8'hFF, 8'h00, 1'b0, z},
         '{OPC_PHP, 8'h00, 8'h00, 1'b0, z},
         '{OPC_LDA, 8'hC3, 8'h00, 1'b0, z},
         '{OPC_PHA, 8'h00, 8'h00, 1'b0, z},
         '{OPC_PLP, 8'h00, 8'h00, 1'b0, z},
         '{OPC_PLA, 8'h00, 8'h00, 1'b0, z},
         '{OPC_LDX, 8'h00, 8'h00, 1'b0, z},
         '{OPC_TXS, 8'h00, 8'h00, 1'b0, z},
         '{OPC_PHA, 8'h00, 8'h00, 1'b0, z},
         '{OPC_TSX, 8'h00, 8'h00, 1'b0, z},
         '{OPC_JSR, 8'hFF, 8'hFF, 1'b0, z},
         '{OPC_RTS, 8'h00, 8'h00, 1'b0, z},
         '{OPC_STA, 8'hFF, 8'h00, 1'b0, z},
         '{OPC_BIT, 8'hFF, 8'h00, 1'b0, z},
         '{OPC_INC, 8'hFF, 8'h00, 1'b0, z},
         '{OPC_DEC, 8'h00, 8'h00, 1'b0, z},
         '{OPC_ROR, 8'h00, 8'h00, 1'b0, z},
         '{OPC_JMP, 8'hFE, 8'hFF, 1'b0, z}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send_instr(rows[i].op, rows[i].lo, rows[i].hi, rows[i].typed, rows[i].want);
         if (i > 8) random_gap();
      end
      // random programs: mostly valid opcodes, occasional junk
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_rx = 1'b1;
         send_instr(random_opcode(), 8'($urandom), 8'($urandom), 1'b0, z);
         if (n >= 300 && n < 320) continue;
         random_gap();
      end
      push <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: random pops, one long hold-off while the sender keeps offering
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            pop <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rx = 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            pop <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
      end
   end

   // check every result transfer against the oldest prediction
   always @(posedge clock) begin
      res_type w;
      if (!reset && pop && !empty) begin
         if (pending_regs.size() == 0) begin
            $display("result with no instruction outstanding");
            fail_count++;
         end else begin
            w = pending_regs.pop_front();
            if (rsp_acc_out !== w.acc) report_mismatch("acc", rsp_acc_out, w.acc);
            if (rsp_x_out !== w.x) report_mismatch("x", rsp_x_out, w.x);
            if (rsp_y_out !== w.y) report_mismatch("y", rsp_y_out, w.y);
            if (rsp_sp_out !== w.sp) report_mismatch("sp", rsp_sp_out, w.sp);
            if (rsp_pc_out !== w.pc) report_mismatch("pc", rsp_pc_out, w.pc);
            if (rsp_flags_out !== w.flags) report_mismatch("flags", rsp_flags_out, w.flags);
            if (rsp_unknown_opcode !== w.unknown)
               report_mismatch("unknown", rsp_unknown_opcode, w.unknown);
         end
      end
   end

   // watchdog and end of run
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("cpu6502_subset_execute_tb: FAIL");
            $finish;
         end
         if (stim_done && pending_regs.size() == 0) begin
            repeat (20) @(posedge clock);
            if (fail_count == 0 && pending_regs.size() == 0)
               $display("cpu6502_subset_execute_tb: PASS");
            else
               $display("cpu6502_subset_execute_tb: FAIL");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/cse_pkg.sv
rtl/core/cse_ram.sv
rtl/core/cse_fifo.sv
rtl/core/cse_front.sv
rtl/core/cse_back.sv
rtl/core/cpu6502_subset_execute.sv
test/cpu6502_subset_execute_tb.sv
